>>> hdl/bbs_pkg.sv
// shared constants for the bollinger band stream core
package bbs_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 12;
    localparam int WL_W       = 7;
    localparam int BM_W       = 12;
    localparam int MID_W      = 24;
    localparam int BAND_W     = 36;
    localparam int PCT_W      = 22;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_MULT     = 4'd1;

    localparam logic [WL_W-1:0] WL_RESET = 7'd20;
    localparam logic [BM_W-1:0] BM_RESET = 12'd512;

    localparam logic signed [PCT_W-1:0] PCTB_LIMIT = 22'sd1048576;
    localparam logic signed [PCT_W-1:0] PCTB_HALF  = 22'sd32768;

endpackage

>>> hdl/bollinger_band_stream_core.sv
// bollinger band stream core: sliding window mean, deviation bands and percent-b
//
// input channel: in_valid / in_stall with one unsigned sample per transfer.
// output channel: out_valid / out_stall with one result per input transfer:
// bands_valid, middle_band, upper_band, lower_band, percent_b.
// one item is worked at a time; in_stall is high from the accepting edge until
// the result has been taken. with the window full the result goes through the
// square root unit and the shared divider, which runs the mean, the deviation
// and percent-b divisions; when the bands meet the percent-b division is
// skipped. with the window not yet full the result skips the square root and
// the divisions. while out_stall is high the result holds and no new sample is
// taken; the next sample can transfer in the cycle after the result transfer.
// configuration: cfg_write with cfg_index and cfg_data, only while idle. a write
// of window_length restarts the window; band_multiplier takes effect on the next
// sample. reset restores window_length 20, band_multiplier 512 and an empty
// window; the ring needs no clearing since a read of an unwritten slot is masked to zero.
module bollinger_band_stream_core
    import bbs_pkg::*;
#(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [SAMPLE_BITS-1:0]    sample,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      bands_valid,
    output logic [MID_W-1:0]          middle_band,
    output logic signed [BAND_W-1:0]  upper_band,
    output logic signed [BAND_W-1:0]  lower_band,
    output logic signed [PCT_W-1:0]   percent_b,
    input  logic                      cfg_write,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    localparam int PTR_W   = $clog2(MAX_WINDOW);
    localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W   = SAMPLE_BITS + CNT_W;
    localparam int SQ_W    = 2 * SAMPLE_BITS + CNT_W;
    localparam int VAR_W   = 2 * SUM_W;
    localparam int ROOT_W  = SUM_W;
    localparam int PROD_W  = BM_W + ROOT_W;
    localparam int DEV_W   = PROD_W - 8;
    localparam int DIFF_W  = DEV_W + 2;
    localparam int DNUM_W  = DIFF_W + 16;
    localparam int DDEN_W  = DEV_W + 1;
    localparam int DSTEP_W = $clog2(DNUM_W + 1);
    localparam int RCNT_W  = $clog2(ROOT_W + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_OLD   = 4'd1;
    localparam logic [3:0] ST_SQA   = 4'd2;
    localparam logic [3:0] ST_SQB   = 4'd3;
    localparam logic [3:0] ST_CHK   = 4'd4;
    localparam logic [3:0] ST_VAR   = 4'd5;
    localparam logic [3:0] ST_SQRT  = 4'd6;
    localparam logic [3:0] ST_SCALE = 4'd7;
    localparam logic [3:0] ST_DEV   = 4'd8;
    localparam logic [3:0] ST_DEVW  = 4'd9;
    localparam logic [3:0] ST_BAND  = 4'd10;
    localparam logic [3:0] ST_PCTW  = 4'd11;
    localparam logic [3:0] ST_OUT   = 4'd12;

    logic [3:0]             state_reg;
    logic [WL_W-1:0]        wl_reg;
    logic [BM_W-1:0]        bm_reg;
    logic [PTR_W-1:0]       wp_reg;
    logic [CNT_W-1:0]       fill_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [SQ_W-1:0]        sq_reg;
    logic [CNT_W-1:0]       n_reg;
    logic                   full_reg;
    logic [SAMPLE_BITS-1:0] s_reg;
    logic [2*SAMPLE_BITS-1:0] mul_reg;
    logic [VAR_W-1:0]       ss_reg;
    logic [VAR_W-1:0]       nq_reg;
    logic [VAR_W-1:0]       val_reg;
    logic [ROOT_W:0]        srem_reg;
    logic [ROOT_W-1:0]      root_reg;
    logic [RCNT_W-1:0]      rcnt_reg;
    logic [SAMPLE_BITS-1:0] mean_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [DEV_W-1:0]       dev_reg;
    logic                   neg_reg;

    logic                   out_valid_reg;
    logic                   bands_valid_reg;
    logic [MID_W-1:0]       middle_reg;
    logic signed [BAND_W-1:0] upper_reg;
    logic signed [BAND_W-1:0] lower_reg;
    logic signed [PCT_W-1:0]  pct_reg;

    logic                   accept;
    logic [CNT_W-1:0]       n_eff;
    logic [31:0]            old_idx32;
    logic [PTR_W-1:0]       old_idx;
    logic [SAMPLE_BITS-1:0] ram_rd_data;
    logic                   ram_wr_en;
    logic [SAMPLE_BITS-1:0] old_val;

    logic [ROOT_W+2:0]      t_rem;
    logic [ROOT_W+2:0]      t_trial;

    logic                   div_start;
    logic [DNUM_W-1:0]      div_num;
    logic [DDEN_W-1:0]      div_den;
    logic [DSTEP_W-1:0]     div_steps;
    logic                   div_busy;
    logic [DNUM_W-1:0]      div_quot;
    logic [DDEN_W-1:0]      div_rem;

    logic [63:0]            upper64;
    logic [63:0]            lower64;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]      diff_mag;
    logic [DNUM_W:0]        q_mag;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        if (wl_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (32'(wl_reg) > MAX_WINDOW)
        begin
            n_eff = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            n_eff = CNT_W'(wl_reg);
        end
        if (32'(wp_reg) >= 32'(n_eff))
        begin
            old_idx32 = 32'(wp_reg) - 32'(n_eff);
        end
        else
        begin
            old_idx32 = 32'(wp_reg) + MAX_WINDOW - 32'(n_eff);
        end
        old_idx = old_idx32[PTR_W-1:0];
    end

    assign ram_wr_en = (state_reg == ST_OLD);
    assign old_val   = full_reg ? ram_rd_data : '0;

    bbs_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wp_reg),
        .wr_data (s_reg),
        .rd_en   (accept),
        .rd_addr (old_idx),
        .rd_data (ram_rd_data)
    );

    // square root step
    assign t_rem   = {srem_reg, val_reg[VAR_W-1:VAR_W-2]};
    assign t_trial = {1'b0, root_reg, 2'b01};

    // divider requests: mean, deviation, percent-b magnitude
    assign upper64  = 64'(mean_reg) + 64'(dev_reg);
    assign lower64  = 64'(mean_reg) - 64'(dev_reg);
    assign diff     = $signed(DIFF_W'(s_reg)) - $signed(DIFF_W'(mean_reg))
                      + $signed(DIFF_W'(dev_reg));
    assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        div_steps = '0;
        unique case (state_reg)
            ST_CHK:
            begin
                div_start = (fill_reg >= n_reg);
                div_num   = {sum_reg, {(DNUM_W-SUM_W){1'b0}}};
                div_den   = DDEN_W'(n_reg);
                div_steps = DSTEP_W'(SUM_W);
            end
            ST_DEV:
            begin
                div_start = 1'b1;
                div_num   = {prod_reg[PROD_W-1:8], {(DNUM_W-DEV_W){1'b0}}};
                div_den   = DDEN_W'(n_reg);
                div_steps = DSTEP_W'(DEV_W);
            end
            ST_BAND:
            begin
                div_start = (dev_reg != '0);
                div_num   = {diff_mag, 16'd0};
                div_den   = {dev_reg, 1'b0};
                div_steps = DSTEP_W'(DNUM_W);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    bbs_div #(
        .NUM_W (DNUM_W),
        .DEN_W (DDEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .steps (div_steps),
        .busy  (div_busy),
        .quot  (div_quot),
        .rem   (div_rem)
    );

    // floor for negative numerators rounds the magnitude up
    assign q_mag = {1'b0, div_quot}
                   + ((neg_reg && div_rem != '0) ? (DNUM_W+1)'(1) : (DNUM_W+1)'(0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wl_reg        <= WL_RESET;
            bm_reg        <= BM_RESET;
            wp_reg        <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            out_valid_reg <= 1'b0;
            rcnt_reg      <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_WINDOW_LENGTH)
                begin
                    wl_reg   <= cfg_data[WL_W-1:0];
                    wp_reg   <= '0;
                    fill_reg <= '0;
                    sum_reg  <= '0;
                    sq_reg   <= '0;
                end
                else if (cfg_index == REG_BAND_MULT)
                begin
                    bm_reg <= cfg_data[BM_W-1:0];
                end
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_OLD;
                    end
                end
                ST_OLD:
                begin
                    sum_reg   <= sum_reg - SUM_W'(old_val) + SUM_W'(s_reg);
                    wp_reg    <= (32'(wp_reg) == MAX_WINDOW - 1) ? '0 : wp_reg + 1'b1;
                    fill_reg  <= full_reg ? n_reg : fill_reg + 1'b1;
                    state_reg <= ST_SQA;
                end
                ST_SQA:
                begin
                    sq_reg    <= sq_reg - SQ_W'(mul_reg);
                    state_reg <= ST_SQB;
                end
                ST_SQB:
                begin
                    sq_reg    <= sq_reg + SQ_W'(mul_reg);
                    state_reg <= ST_CHK;
                end
                ST_CHK:
                begin
                    if (fill_reg >= n_reg)
                    begin
                        state_reg <= ST_VAR;
                    end
                    else
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_OUT;
                    end
                end
                ST_VAR:
                begin
                    rcnt_reg  <= RCNT_W'(ROOT_W);
                    state_reg <= ST_SQRT;
                end
                ST_SQRT:
                begin
                    rcnt_reg <= rcnt_reg - 1'b1;
                    if (rcnt_reg == RCNT_W'(1))
                    begin
                        state_reg <= ST_SCALE;
                    end
                end
                ST_SCALE:
                begin
                    if (!div_busy)
                    begin
                        state_reg <= ST_DEV;
                    end
                end
                ST_DEV:
                begin
                    state_reg <= ST_DEVW;
                end
                ST_DEVW:
                begin
                    if (!div_busy)
                    begin
                        state_reg <= ST_BAND;
                    end
                end
                ST_BAND:
                begin
                    if (dev_reg == '0)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_OUT;
                    end
                    else
                    begin
                        state_reg <= ST_PCTW;
                    end
                end
                ST_PCTW:
                begin
                    if (!div_busy)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_reg    <= sample;
            n_reg    <= n_eff;
            full_reg <= (fill_reg >= n_eff);
        end
        unique case (state_reg)
            ST_OLD:
            begin
                mul_reg <= (2*SAMPLE_BITS)'(old_val) * (2*SAMPLE_BITS)'(old_val);
            end
            ST_SQA:
            begin
                mul_reg <= (2*SAMPLE_BITS)'(s_reg) * (2*SAMPLE_BITS)'(s_reg);
            end
            ST_CHK:
            begin
                ss_reg          <= VAR_W'(sum_reg) * VAR_W'(sum_reg);
                nq_reg          <= VAR_W'(n_reg) * VAR_W'(sq_reg);
                bands_valid_reg <= 1'b0;
                middle_reg      <= '0;
                upper_reg       <= '0;
                lower_reg       <= '0;
                pct_reg         <= '0;
            end
            ST_VAR:
            begin
                val_reg  <= (nq_reg >= ss_reg) ? nq_reg - ss_reg : '0;
                srem_reg <= '0;
                root_reg <= '0;
            end
            ST_SQRT:
            begin
                val_reg <= {val_reg[VAR_W-3:0], 2'b00};
                if (t_rem >= t_trial)
                begin
                    srem_reg <= (ROOT_W+1)'(t_rem - t_trial);
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    srem_reg <= t_rem[ROOT_W:0];
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
            end
            ST_SCALE:
            begin
                mean_reg <= div_quot[SAMPLE_BITS-1:0];
                prod_reg <= PROD_W'(bm_reg) * PROD_W'(root_reg);
            end
            ST_DEVW:
            begin
                dev_reg <= div_quot[DEV_W-1:0];
            end
            ST_BAND:
            begin
                neg_reg         <= diff[DIFF_W-1];
                bands_valid_reg <= 1'b1;
                middle_reg      <= MID_W'(mean_reg);
                upper_reg       <= upper64[BAND_W-1:0];
                lower_reg       <= lower64[BAND_W-1:0];
                pct_reg         <= PCTB_HALF;
            end
            ST_PCTW:
            begin
                if (q_mag > (DNUM_W+1)'(PCTB_LIMIT))
                begin
                    pct_reg <= neg_reg ? -PCTB_LIMIT : PCTB_LIMIT;
                end
                else if (neg_reg)
                begin
                    pct_reg <= -$signed(q_mag[PCT_W-1:0]);
                end
                else
                begin
                    pct_reg <= $signed(q_mag[PCT_W-1:0]);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign bands_valid = bands_valid_reg;
    assign middle_band = middle_reg;
    assign upper_band  = upper_reg;
    assign lower_band  = lower_reg;
    assign percent_b   = pct_reg;

endmodule

>>> hdl/bbs_ram.sv
// generic one-write one-read ram with registered read
module bbs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hdl/bbs_div.sv
// iterative unsigned divider, one quotient bit per cycle, left-aligned dividend
module bbs_div #(
    parameter int NUM_W = 52,
    parameter int DEN_W = 36
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [NUM_W-1:0]           num,
    input  logic [DEN_W-1:0]           den,
    input  logic [$clog2(NUM_W+1)-1:0] steps,
    output logic                       busy,
    output logic [NUM_W-1:0]           quot,
    output logic [DEN_W-1:0]           rem
);

    localparam int STEP_W = $clog2(NUM_W+1);

    logic              busy_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [NUM_W-1:0]  sh_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W:0]    trial;
    logic              fits;

    assign trial = {rem_reg, sh_reg[NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= (steps != '0);
            cnt_reg  <= steps;
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != STEP_W'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            sh_reg <= {sh_reg[NUM_W-2:0], fits};
            if (fits)
            begin
                rem_reg <= DEN_W'(trial - {1'b0, den_reg});
            end
            else
            begin
                rem_reg <= trial[DEN_W-1:0];
            end
        end
    end

    assign busy = busy_reg;
    assign quot = sh_reg;
    assign rem  = rem_reg;

endmodule
